[rtl/barometric_sensor_compensation_core_assert.svh]
// assertion macros for the compensation core
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BSC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bsc_pkg.sv]
// shared types and constants of the compensation core
package bsc_pkg;

    localparam int DIV_STEPS = 32;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_B4_OFS   = 32'd32768;
    localparam logic [31:0] C_B7_SCALE = 32'd50000;
    localparam logic [31:0] C_P_K1     = 32'd1519;
    localparam logic [31:0] C_P_K2     = 32'd7357;
    localparam logic [31:0] C_P_K3     = 32'd3791;
    localparam logic [31:0] C_P_MAX    = 32'd262143;

    typedef enum logic [2:0] {
        REG_AC1  = 3'd0,
        REG_AC2  = 3'd1,
        REG_AC3  = 3'd2,
        REG_AC456 = 3'd3,
        REG_B1B2 = 3'd4,
        REG_MCMD = 3'd5,
        REG_OSS  = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } coef_t;

    // sideband carried through a divider
    typedef struct packed {
        logic        err;
        logic        neg;
        logic [31:0] a;
        logic [18:0] up;
        logic [15:0] t;
    } side_t;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [15:0] t;
        logic [31:0] b6;
        logic [18:0] up;
    } temp_item_t;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [15:0] t;
        logic [31:0] b7;
        logic [31:0] b4;
    } press_item_t;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [15:0] t;
        logic [31:0] pp;
    } pp_item_t;

    typedef struct packed {
        logic        valid;
        logic        err;
        logic [15:0] t;
        logic [17:0] p;
    } res_t;

endpackage

[rtl/bsc_udiv.sv]
// pipelined unsigned 32/32 divider, one quotient bit per stage
module bsc_udiv import bsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [31:0] quotient,
    output side_t       side_out
);

    logic        vld_reg [0:DIV_STEPS];
    logic [31:0] rem_reg [0:DIV_STEPS];
    logic [31:0] dq_reg  [0:DIV_STEPS];
    logic [31:0] dvs_reg [0:DIV_STEPS];
    side_t       sd_reg  [0:DIV_STEPS];

    assign vld_reg[0] = in_valid;
    assign rem_reg[0] = '0;
    assign dq_reg[0]  = dividend;
    assign dvs_reg[0] = divisor;
    assign sd_reg[0]  = side_in;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        assign trial = {rem_reg[k], dq_reg[k][31]};
        assign diff  = trial - {1'b0, dvs_reg[k]};
        assign ge    = ~diff[32];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= ge ? diff[31:0] : trial[31:0];
                dq_reg[k+1]  <= {dq_reg[k][30:0], ge};
                dvs_reg[k+1] <= dvs_reg[k];
                sd_reg[k+1]  <= sd_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign quotient  = dq_reg[DIV_STEPS];
    assign side_out  = sd_reg[DIV_STEPS];

endmodule

[rtl/bsc_coef.sv]
// pressure coefficient stages: b3, b4 and b7 from b6
module bsc_coef import bsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  coef_t       coef,
    input  temp_item_t  in_item,
    output press_item_t out_item
);

    logic [31:0] ac1_x, ac2_x, ac3_x, b1_x, b2_x;
    logic [31:0] scale;

    assign ac1_x = {{16{coef.ac1[15]}}, coef.ac1};
    assign ac2_x = {{16{coef.ac2[15]}}, coef.ac2};
    assign ac3_x = {{16{coef.ac3[15]}}, coef.ac3};
    assign b1_x  = {{16{coef.b1[15]}}, coef.b1};
    assign b2_x  = {{16{coef.b2[15]}}, coef.b2};
    assign scale = C_B7_SCALE >> coef.oss;

    // stage 4: squares and linear products of b6
    logic        v4_reg, e4_reg;
    logic [15:0] t4_reg;
    logic [18:0] up4_reg;
    logic [31:0] sq_reg, pa2_reg, pa3_reg;

    // stage 5
    logic        v5_reg, e5_reg;
    logic [15:0] t5_reg;
    logic [18:0] up5_reg;
    logic [31:0] mb2_reg, mb1_reg, x2a_reg, x1c_reg;
    logic [31:0] s12;

    // stage 6
    logic        v6_reg, e6_reg;
    logic [15:0] t6_reg;
    logic [18:0] up6_reg;
    logic [31:0] b3_reg, v_reg;
    logic [31:0] x1b, x2b;
    logic [31:0] x3, b3_next, x3p, v_next;

    // stage 7
    logic        v7_reg, e7_reg;
    logic [15:0] t7_reg;
    logic [31:0] b4_reg, diff_reg, b4_prod;

    // stage 8
    logic        v8_reg, e8_reg;
    logic [15:0] t8_reg;
    logic [31:0] b4o_reg, b7_reg;

    // arithmetic shifts kept in their own assignments so the sums stay unsigned
    assign s12     = $signed(sq_reg) >>> 12;
    assign x1b     = $signed(mb2_reg) >>> 11;
    assign x2b     = $signed(mb1_reg) >>> 16;
    assign x3      = x1b + x2a_reg;
    assign b3_next = $signed((((ac1_x << 2) + x3) << coef.oss) + 32'd2) >>> 2;
    assign x3p     = $signed(x1c_reg + x2b + 32'd2) >>> 2;
    assign v_next  = x3p + C_B4_OFS;
    assign b4_prod = {16'd0, coef.ac4} * v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_item.valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e4_reg   <= in_item.err;
            t4_reg   <= in_item.t;
            up4_reg  <= in_item.up;
            sq_reg   <= in_item.b6 * in_item.b6;
            pa2_reg  <= ac2_x * in_item.b6;
            pa3_reg  <= ac3_x * in_item.b6;

            e5_reg   <= e4_reg;
            t5_reg   <= t4_reg;
            up5_reg  <= up4_reg;
            mb2_reg  <= s12 * b2_x;
            mb1_reg  <= s12 * b1_x;
            x2a_reg  <= $signed(pa2_reg) >>> 11;
            x1c_reg  <= $signed(pa3_reg) >>> 13;

            e6_reg   <= e5_reg;
            t6_reg   <= t5_reg;
            up6_reg  <= up5_reg;
            b3_reg   <= b3_next;
            v_reg    <= v_next;

            e7_reg   <= e6_reg;
            t7_reg   <= t6_reg;
            b4_reg   <= b4_prod >> 15;
            diff_reg <= {13'd0, up6_reg} - b3_reg;

            e8_reg   <= e7_reg | (b4_reg == 32'd0);
            t8_reg   <= t7_reg;
            b4o_reg  <= b4_reg;
            b7_reg   <= diff_reg * scale;
        end
    end

    assign out_item = '{valid: v8_reg, err: e8_reg, t: t8_reg, b7: b7_reg, b4: b4o_reg};

endmodule

[rtl/bsc_tail.sv]
// final pressure correction and clamping
module bsc_tail import bsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  pp_item_t in_item,
    output res_t     res
);

    logic        v9_reg, e9_reg;
    logic [15:0] t9_reg;
    logic [31:0] pp9_reg, sqx_reg, m7_reg;
    logic [31:0] x1s;

    logic        v10_reg, e10_reg;
    logic [15:0] t10_reg;
    logic [31:0] pp10_reg, a_reg, x2_reg;

    logic [31:0]        a_s, sum, sum_s;
    logic signed [31:0] p;
    logic [17:0]        p_clamped;

    assign x1s = $signed(in_item.pp) >>> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end else if (en) begin
            v9_reg  <= in_item.valid;
            v10_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e9_reg   <= in_item.err;
            t9_reg   <= in_item.t;
            pp9_reg  <= in_item.pp;
            sqx_reg  <= x1s * x1s;
            m7_reg   <= 32'd0 - C_P_K2 * in_item.pp;

            e10_reg  <= e9_reg;
            t10_reg  <= t9_reg;
            pp10_reg <= pp9_reg;
            a_reg    <= sqx_reg * C_P_K1;
            x2_reg   <= $signed(m7_reg) >>> 16;
        end
    end

    // arithmetic shifts kept in their own assignments so the sums stay unsigned
    assign a_s   = $signed(a_reg) >>> 15;
    assign sum   = a_s + x2_reg + C_P_K3;
    assign sum_s = $signed(sum) >>> 4;
    assign p     = $signed(pp10_reg + sum_s);

    always_comb begin
        if (p < 0) begin
            p_clamped = '0;
        end else if (p > $signed(C_P_MAX)) begin
            p_clamped = C_P_MAX[17:0];
        end else begin
            p_clamped = p[17:0];
        end
    end

    assign res.valid = v10_reg;
    assign res.err   = e10_reg;
    assign res.t     = e10_reg ? 16'd0 : t10_reg;
    assign res.p     = e10_reg ? 18'd0 : p_clamped;

endmodule

[rtl/barometric_sensor_compensation_core.sv]
// top level of the barometric compensation core: registers, temperature path, pipeline
//
//  channel   ports                                   beat carries
//  s_        s_valid s_ready                         raw_temperature, raw_pressure
//  m_        m_valid m_ready                         temperature_tenths, pressure_pa, math_error
//  apb       psel penable pwrite paddr pwdata prdata  coefficients at 8*i, 64-bit data
//
// one beat enters per cycle unless m_ stalls; the pipeline depth is set by two
// 32-stage dividers, plus 10 arithmetic and output stages
// every stage advances together; a stall on m_ while m_valid holds freezes the
// whole pipeline and drops s_ready in the same cycle
// synchronous active-low reset clears valid bits and the coefficients
module barometric_sensor_compensation_core import bsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_raw_temperature,
    input  logic [23:0] s_raw_pressure,
    // result beats
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_temperature_tenths,
    output logic [17:0] m_pressure_pa,
    output logic        m_math_error,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // coefficient registers
    // ---------------------------------------------------------------
    logic [15:0] ac1_reg, ac2_reg, ac3_reg;
    logic [47:0] ac456_reg;
    logic [31:0] b1b2_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic        wr_en;
    reg_idx_t    widx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign widx   = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_reg   <= '0;
            ac2_reg   <= '0;
            ac3_reg   <= '0;
            ac456_reg <= '0;
            b1b2_reg  <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
        end else if (wr_en) begin
            unique case (widx)
                REG_AC1:   ac1_reg   <= pwdata[15:0];
                REG_AC2:   ac2_reg   <= pwdata[15:0];
                REG_AC3:   ac3_reg   <= pwdata[15:0];
                REG_AC456: ac456_reg <= pwdata[47:0];
                REG_B1B2:  b1b2_reg  <= pwdata[31:0];
                REG_MCMD:  mcmd_reg  <= pwdata[31:0];
                REG_OSS:   oss_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (widx)
            REG_AC1:   prdata = {48'd0, ac1_reg};
            REG_AC2:   prdata = {48'd0, ac2_reg};
            REG_AC3:   prdata = {48'd0, ac3_reg};
            REG_AC456: prdata = {16'd0, ac456_reg};
            REG_B1B2:  prdata = {32'd0, b1b2_reg};
            REG_MCMD:  prdata = {32'd0, mcmd_reg};
            REG_OSS:   prdata = {62'd0, oss_reg};
            default:   prdata = '0;
        endcase
    end

    coef_t coef;
    assign coef = '{ac1: ac1_reg, ac2: ac2_reg, ac3: ac3_reg,
                    ac4: ac456_reg[47:32], ac5: ac456_reg[31:16], ac6: ac456_reg[15:0],
                    b1: b1b2_reg[31:16], b2: b1b2_reg[15:0],
                    mc: mcmd_reg[31:16], md: mcmd_reg[15:0], oss: oss_reg};

    // ---------------------------------------------------------------
    // global stage enable: everything moves unless the output is stuck
    // ---------------------------------------------------------------
    logic pipe_en;
    assign pipe_en = ~m_valid | m_ready;
    assign s_ready = pipe_en;

    // ---------------------------------------------------------------
    // stage 1: temperature product and pressure alignment
    // ---------------------------------------------------------------
    logic        v1_reg;
    logic [31:0] prod1_reg;
    logic [18:0] up1_reg;
    logic signed [16:0] ut_diff;
    logic signed [33:0] prod1_full;
    logic [23:0]        up_full;

    assign ut_diff    = $signed({1'b0, s_raw_temperature}) - $signed({1'b0, coef.ac6});
    assign prod1_full = ut_diff * $signed({1'b0, coef.ac5});
    assign up_full    = s_raw_pressure >> (4'd8 - {2'b00, coef.oss});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            prod1_reg <= prod1_full[31:0];
            up1_reg   <= up_full[18:0];
        end
    end

    // ---------------------------------------------------------------
    // stage 2: mc*2^11 / (x1 + md), signed, via magnitudes
    // ---------------------------------------------------------------
    logic [31:0] x1_t, den, num, abs_num, abs_den;
    side_t       side1_in, side1_out;
    logic        d1_valid;
    logic [31:0] q1;

    assign x1_t    = $signed(prod1_reg) >>> 15;
    assign den     = x1_t + {{16{coef.md[15]}}, coef.md};
    assign num     = {{5{coef.mc[15]}}, coef.mc, 11'd0};
    assign abs_num = num[31] ? (32'd0 - num) : num;
    assign abs_den = den[31] ? (32'd0 - den) : den;
    assign side1_in = '{err: (den == 32'd0), neg: num[31] ^ den[31],
                        a: x1_t, up: up1_reg, t: 16'd0};

    bsc_udiv u_div_temp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v1_reg),
        .dividend  (abs_num),
        .divisor   (abs_den),
        .side_in   (side1_in),
        .out_valid (d1_valid),
        .quotient  (q1),
        .side_out  (side1_out)
    );

    // ---------------------------------------------------------------
    // stage 3: b5, saturated temperature, b6
    // ---------------------------------------------------------------
    logic [31:0]        x2_t, b5;
    logic signed [31:0] t_shift;
    logic [15:0]        t_sat;
    temp_item_t         t3_reg;

    assign x2_t    = side1_out.neg ? (32'd0 - q1) : q1;
    assign b5      = side1_out.a + x2_t;
    assign t_shift = $signed(b5 + 32'd8) >>> 4;

    always_comb begin
        if (t_shift > 32'sd32767) begin
            t_sat = 16'h7fff;
        end else if (t_shift < -32'sd32768) begin
            t_sat = 16'h8000;
        end else begin
            t_sat = t_shift[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t3_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            t3_reg.valid <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            t3_reg.err <= side1_out.err;
            t3_reg.t   <= t_sat;
            t3_reg.b6  <= b5 - C_B6_OFS;
            t3_reg.up  <= side1_out.up;
        end
    end

    // ---------------------------------------------------------------
    // stages 4..8: b3, b4, b7
    // ---------------------------------------------------------------
    press_item_t pr;

    bsc_coef u_coef (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .coef     (coef),
        .in_item  (t3_reg),
        .out_item (pr)
    );

    // ---------------------------------------------------------------
    // pressure division; b7 with its top bit set divides first, doubles after
    // ---------------------------------------------------------------
    side_t       side2_in, side2_out;
    logic        d2_valid;
    logic [31:0] q2;
    pp_item_t    pp_item;

    assign side2_in = '{err: pr.err, neg: pr.b7[31], a: 32'd0, up: 19'd0, t: pr.t};

    bsc_udiv u_div_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (pr.valid),
        .dividend  (pr.b7[31] ? pr.b7 : {pr.b7[30:0], 1'b0}),
        .divisor   (pr.b4),
        .side_in   (side2_in),
        .out_valid (d2_valid),
        .quotient  (q2),
        .side_out  (side2_out)
    );

    assign pp_item = '{valid: d2_valid, err: side2_out.err, t: side2_out.t,
                       pp: side2_out.neg ? {q2[30:0], 1'b0} : q2};

    // ---------------------------------------------------------------
    // stages 9..10: correction polynomial and clamp
    // ---------------------------------------------------------------
    res_t tail_res;

    bsc_tail u_tail (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_item (pp_item),
        .res     (tail_res)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic        m_valid_reg;
    logic [15:0] m_t_reg;
    logic [17:0] m_p_reg;
    logic        m_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= tail_res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_t_reg   <= tail_res.t;
            m_p_reg   <= tail_res.p;
            m_err_reg <= tail_res.err;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_temperature_tenths = m_t_reg;
    assign m_pressure_pa        = m_p_reg;
    assign m_math_error         = m_err_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
`include "barometric_sensor_compensation_core_assert.svh"

    `BSC_ASSERT_NOW(a_err_zero, m_valid && m_math_error, (m_temperature_tenths == 16'd0) && (m_pressure_pa == 18'd0), "error beat with nonzero results")
    `BSC_ASSERT_NEXT(a_tail_load, pipe_en && tail_res.valid, m_valid, "finished beat not loaded into output")
    `BSC_ASSERT_NOW(a_stall_ready, m_valid && !m_ready, !s_ready, "input taken while pipeline frozen")

endmodule
